[design/generational_handle_allocator_defines.svh]
// ============================================================================
// Generational handle allocator assertion macros
// Shared forms of the concurrent checks, clocked on clk and held off in reset.
// ============================================================================
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define GHA_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define GHA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define GHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/gha_pkg.sv]
// ============================================================================
// Generational handle allocator package
// Request and response payload types and the operation and status codes.
// ============================================================================
`timescale 1ns / 1ps

package gha_pkg;

	localparam int GEN_W = 32;

	typedef enum logic [1:0] {
		MODE_ALLOC  = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_NOT_LIVE = 2'd2,
		STAT_BEYOND   = 2'd3
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [7:0]         slot_index;
		logic [GEN_W-1:0]   handle_generation;
		logic [7:0]         list_position;
	} gha_req_t;

	typedef struct packed {
		status_t            status;
		logic [7:0]         out_index;
		logic [GEN_W-1:0]   out_generation;
		logic               is_live;
		logic [8:0]         live_count;
	} gha_rsp_t;

endpackage

[design/generational_handle_allocator.sv]
// ============================================================================
// Generational handle allocator
// Hands out slot handles with generations, keeps a dense list of live handles
// and a LIFO stack of freed slots, all held in synchronous memories.
// ============================================================================
//
// Channel  Dir  Payload    Handshake
// req      in   gha_req_t  req_valid / req_stall
// rsp      out  gha_rsp_t  rsp_valid / rsp_stall
//
// An allocate of a never-used slot, and any request that fails its range
// check, completes in the cycle it is accepted. Query, read and a stale
// remove finish in ST_S2; an allocate from the free stack and a good remove
// go on to ST_S3, set by the chain of dependent memory reads.
// Reset clears state, counters and output valid only. Slots at or above
// the high-water mark are never read; the memories need no clearing pass.
// A result waits in the output register while the next request is taken; a
// second result that finds it still full parks in a holding register and
// stalls the request side until it moves out.
`timescale 1ns / 1ps
`include "generational_handle_allocator_defines.svh"

module generational_handle_allocator
	import gha_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  gha_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output gha_rsp_t rsp
);

	localparam int IW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int XW  = (CW > 8) ? CW : 8;
	localparam int SMW = GEN_W + 1;
	localparam int LLW = IW + GEN_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_S2   = 4'b0010,
		ST_S3   = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	mode_t            mode_q, mode_d;
	logic [IW-1:0]    slot_q, slot_d;
	logic [GEN_W-1:0] gen_q, gen_d;
	logic [IW-1:0]    at_q, at_d;
	logic [IW-1:0]    last_q, last_d;
	logic [CW-1:0]    free_depth_q, fd_d;
	logic [CW-1:0]    high_water_q, hw_d;
	logic [CW-1:0]    live_total_q, lt_d;
	logic [CW-1:0]    fd_m1, lt_m1, lt_p1;
	logic [XW-1:0]    req_idx_x, req_pos_x, hw_x, lt_x;

	gha_rsp_t out_q, res_q, fin_res;
	logic     out_valid_q, fin, out_free;

	// Slot memory holds {alive, generation}; live list holds {slot, generation}.
	logic             sm_we;
	logic [IW-1:0]    sm_waddr, sm_raddr;
	logic [SMW-1:0]   sm_wdata, sm_rdata;
	logic             fs_we;
	logic [IW-1:0]    fs_waddr, fs_raddr, fs_wdata, fs_rdata;
	logic             ll_we;
	logic [IW-1:0]    ll_waddr, ll_raddr;
	logic [LLW-1:0]   ll_wdata, ll_rdata;
	logic             lp_we;
	logic [IW-1:0]    lp_waddr, lp_raddr, lp_wdata, lp_rdata;

	gha_ram #(.DEPTH(CAPACITY), .WIDTH(SMW)) u_slot_ram (
		.clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
		.raddr(sm_raddr), .rdata(sm_rdata)
	);

	gha_ram #(.DEPTH(CAPACITY), .WIDTH(IW)) u_free_ram (
		.clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
		.raddr(fs_raddr), .rdata(fs_rdata)
	);

	gha_ram #(.DEPTH(CAPACITY), .WIDTH(LLW)) u_list_ram (
		.clk(clk), .we(ll_we), .waddr(ll_waddr), .wdata(ll_wdata),
		.raddr(ll_raddr), .rdata(ll_rdata)
	);

	gha_ram #(.DEPTH(CAPACITY), .WIDTH(IW)) u_pos_ram (
		.clk(clk), .we(lp_we), .waddr(lp_waddr), .wdata(lp_wdata),
		.raddr(lp_raddr), .rdata(lp_rdata)
	);

	assign fd_m1     = free_depth_q - CW'(1);
	assign lt_m1     = live_total_q - CW'(1);
	assign lt_p1     = live_total_q + CW'(1);
	assign req_idx_x = XW'(req.slot_index);
	assign req_pos_x = XW'(req.list_position);
	assign hw_x      = XW'(high_water_q);
	assign lt_x      = XW'(live_total_q);
	assign out_free  = !out_valid_q || !rsp_stall;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Only one request is in flight and each memory is read and written in
	// different cycles of it, so no two accesses to an entry ever overlap.
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		slot_d  = slot_q;
		gen_d   = gen_q;
		at_d    = at_q;
		last_d  = last_q;
		fd_d    = free_depth_q;
		hw_d    = high_water_q;
		lt_d    = live_total_q;

		sm_we    = 1'b0;
		sm_waddr = slot_q;
		sm_wdata = '0;
		sm_raddr = slot_q;
		fs_we    = 1'b0;
		fs_waddr = free_depth_q[IW-1:0];
		fs_wdata = slot_q;
		fs_raddr = fd_m1[IW-1:0];
		ll_we    = 1'b0;
		ll_waddr = live_total_q[IW-1:0];
		ll_wdata = '0;
		ll_raddr = lt_m1[IW-1:0];
		lp_we    = 1'b0;
		lp_waddr = slot_q;
		lp_wdata = live_total_q[IW-1:0];
		lp_raddr = slot_q;

		fin                    = 1'b0;
		fin_res.status         = STAT_OK;
		fin_res.out_index      = '0;
		fin_res.out_generation = '0;
		fin_res.is_live        = 1'b0;
		fin_res.live_count     = 9'(live_total_q);

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					mode_d = req.mode;
					gen_d  = req.handle_generation;
					slot_d = req_idx_x[IW-1:0];
					unique case (req.mode)
						MODE_ALLOC: begin
							if (free_depth_q != '0) begin
								fs_raddr = fd_m1[IW-1:0];
								fd_d     = fd_m1;
								state_d  = ST_S2;
							end else if (high_water_q != CAP_C) begin
								// A never-used slot starts at generation zero.
								hw_d     = high_water_q + CW'(1);
								sm_we    = 1'b1;
								sm_waddr = high_water_q[IW-1:0];
								sm_wdata = {1'b1, {GEN_W{1'b0}}};
								lp_we    = 1'b1;
								lp_waddr = high_water_q[IW-1:0];
								lp_wdata = live_total_q[IW-1:0];
								ll_we    = 1'b1;
								ll_waddr = live_total_q[IW-1:0];
								ll_wdata = {high_water_q[IW-1:0], {GEN_W{1'b0}}};
								lt_d     = lt_p1;
								fin      = 1'b1;
								fin_res.out_index  = 8'(high_water_q);
								fin_res.live_count = 9'(lt_p1);
							end else begin
								fin            = 1'b1;
								fin_res.status = STAT_FULL;
							end
						end
						MODE_REMOVE, MODE_QUERY: begin
							if (req_idx_x < hw_x) begin
								sm_raddr = req_idx_x[IW-1:0];
								lp_raddr = req_idx_x[IW-1:0];
								state_d  = ST_S2;
							end else begin
								fin = 1'b1;
								if (req.mode == MODE_REMOVE) begin
									fin_res.status = STAT_NOT_LIVE;
								end
							end
						end
						MODE_READ: begin
							if (req_pos_x < lt_x) begin
								ll_raddr = req_pos_x[IW-1:0];
								state_d  = ST_S2;
							end else begin
								fin            = 1'b1;
								fin_res.status = STAT_BEYOND;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_S2: begin
				unique case (mode_q)
					MODE_ALLOC: begin
						slot_d   = fs_rdata;
						sm_raddr = fs_rdata;
						state_d  = ST_S3;
					end
					MODE_REMOVE: begin
						if (sm_rdata[GEN_W] && (sm_rdata[GEN_W-1:0] == gen_q)) begin
							sm_we    = 1'b1;
							sm_waddr = slot_q;
							sm_wdata = {1'b0, gen_q + GEN_W'(1)};
							gen_d    = gen_q + GEN_W'(1);
							if (free_depth_q != CAP_C) begin
								fs_we    = 1'b1;
								fs_waddr = free_depth_q[IW-1:0];
								fs_wdata = slot_q;
								fd_d     = free_depth_q + CW'(1);
							end
							// Fetch the tail entry that fills the hole.
							ll_raddr = lt_m1[IW-1:0];
							lt_d     = lt_m1;
							at_d     = lp_rdata;
							last_d   = lt_m1[IW-1:0];
							state_d  = ST_S3;
						end else begin
							fin            = 1'b1;
							fin_res.status = STAT_NOT_LIVE;
						end
					end
					MODE_QUERY: begin
						fin             = 1'b1;
						fin_res.is_live = sm_rdata[GEN_W] && (sm_rdata[GEN_W-1:0] == gen_q);
					end
					MODE_READ: begin
						fin                    = 1'b1;
						fin_res.out_index      = 8'(ll_rdata[LLW-1:GEN_W]);
						fin_res.out_generation = ll_rdata[GEN_W-1:0];
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_S3: begin
				unique case (mode_q)
					MODE_ALLOC: begin
						sm_we    = 1'b1;
						sm_waddr = slot_q;
						sm_wdata = {1'b1, sm_rdata[GEN_W-1:0]};
						lp_we    = 1'b1;
						lp_waddr = slot_q;
						lp_wdata = live_total_q[IW-1:0];
						ll_we    = 1'b1;
						ll_waddr = live_total_q[IW-1:0];
						ll_wdata = {slot_q, sm_rdata[GEN_W-1:0]};
						lt_d     = lt_p1;
						fin      = 1'b1;
						fin_res.out_index      = 8'(slot_q);
						fin_res.out_generation = sm_rdata[GEN_W-1:0];
						fin_res.live_count     = 9'(lt_p1);
					end
					MODE_REMOVE: begin
						if (at_q != last_q) begin
							ll_we    = 1'b1;
							ll_waddr = at_q;
							ll_wdata = ll_rdata;
							lp_we    = 1'b1;
							lp_waddr = ll_rdata[LLW-1:GEN_W];
							lp_wdata = at_q;
						end
						fin                    = 1'b1;
						fin_res.out_index      = 8'(slot_q);
						fin_res.out_generation = gen_q;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			free_depth_q <= '0;
			high_water_q <= '0;
			live_total_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			free_depth_q <= fd_d;
			high_water_q <= hw_d;
			live_total_q <= lt_d;
			if (out_free) begin
				out_valid_q <= fin || (state_q == ST_HOLD);
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_q <= mode_d;
		slot_q <= slot_d;
		gen_q  <= gen_d;
		at_q   <= at_d;
		last_q <= last_d;
		if (fin && !out_free) begin
			res_q <= fin_res;
		end
		if (out_free && fin) begin
			out_q <= fin_res;
		end else if (out_free && (state_q == ST_HOLD)) begin
			out_q <= res_q;
		end
	end

	// Every slot ever handed out is either live or waiting on the free stack.
	`GHA_ASSERT_SAME(a_slot_balance, (state_q == ST_IDLE) || (state_q == ST_HOLD), (CW+1)'(free_depth_q) + (CW+1)'(live_total_q) == (CW+1)'(high_water_q), "used slots are neither live nor free")
	`GHA_ASSERT_ALWAYS(a_high_water_cap, high_water_q <= CAP_C, "high-water mark beyond capacity")
	`GHA_ASSERT_SAME(a_hole_in_list, (state_q == ST_S3) && (mode_q == MODE_REMOVE), at_q <= last_q, "removed handle sits past the list tail")
	`GHA_ASSERT_SAME(a_hold_needs_busy_out, state_q == ST_HOLD, out_valid_q, "result parked while the output register is empty")
	`GHA_ASSERT_NEXT(a_no_lost_request, req_valid && !req_stall, out_valid_q || (state_q != ST_IDLE), "accepted request left no trace")

endmodule

[design/gha_ram.sv]
// ============================================================================
// Generational handle allocator RAM
// Simple dual-port synchronous memory: one write port, one read port with a
// registered read.
// ============================================================================
`timescale 1ns / 1ps

module gha_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
